// File: hw/rtl/tps_pkg.sv
package tps_pkg;

  // Table geometry.
  localparam int unsigned DEVICES = 16;
  localparam int unsigned BUSES   = 2;
  localparam int unsigned ENTRIES = BUSES * DEVICES;
  localparam int unsigned IDX_W   = $clog2(DEVICES);
  localparam int unsigned CNT_W   = $clog2(DEVICES + 1);
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);

  // Field widths.
  localparam int unsigned ID_W     = 8;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned PRIO_W   = 7;
  localparam int unsigned MISS_W   = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BUS_W    = 1;
  localparam int unsigned STRAT_W  = 2;
  localparam int unsigned AGE_W    = FRAME_W + 1;
  localparam int unsigned SCORE_W  = PRIO_W + AGE_W;
  localparam int unsigned BOOST_W  = MISS_W + 2;

  // Stream packing.
  localparam int unsigned IN_TDATA_W  = ID_W + FRAME_W;
  localparam int unsigned IN_TUSER_W  = MODE_W + BUS_W;
  localparam int unsigned OUT_TDATA_W = ID_W;

  // Constants of the scheduling rules.
  localparam logic [ID_W-1:0]   NO_DEVICE      = 8'hFF;
  localparam logic [ID_W-1:0]   ID_NONE        = 8'h00;
  localparam logic [MISS_W-1:0] MISS_THRESHOLD = 8'd10;
  localparam logic [MISS_W-1:0] MISS_MAX       = 8'hFF;
  localparam logic [PRIO_W-1:0] PRIO_CAP       = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_START     = 7'd50;
  localparam logic [PRIO_W-1:0] PRIO_HIGH      = 7'd80;
  localparam logic [PRIO_W-1:0] PRIO_MID       = 7'd50;
  localparam logic [PRIO_W-1:0] PRIO_LOW       = 7'd30;
  localparam logic [PRIO_W-1:0] PRIO_LOWEST    = 7'd20;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_REQUEST = 2'd2,
    MODE_SELECT  = 2'd3
  } mode_e;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_RR    = 2'd0,
    STRAT_FIXED = 2'd1,
    STRAT_ADAPT = 2'd2,
    STRAT_NONE  = 2'd3
  } strategy_e;

  // Operation carried out by the table scan.
  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_FIXED   = 2'd1,
    OP_ADAPT   = 2'd2
  } op_e;

  // One device table entry as stored in the entry RAM.
  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [PRIO_W-1:0]  fixed_prio;
    logic [FRAME_W-1:0] last_frame;
    logic [MISS_W-1:0]  miss_count;
    logic [PRIO_W-1:0]  adapt_prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Result of evaluating one entry in the shared unit.
  typedef struct packed {
    logic               match;
    logic [SCORE_W-1:0] score;
    entry_t             upd;
  } eval_t;

  // Fixed priority of a new device, from the upper nibble of its id.
  function automatic logic [PRIO_W-1:0] prio_of(input logic [ID_W-1:0] id);
    logic [PRIO_W-1:0] p;
    unique case (id[7:4]) inside
      4'h0, 4'h1, 4'h2: p = PRIO_HIGH;
      4'h3:             p = PRIO_MID;
      4'h4:             p = PRIO_LOW;
      4'hB:             p = PRIO_LOWEST;
      default:          p = PRIO_MID;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/tps_ram.sv
module tps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/tps_eval.sv
module tps_eval (
  input  tps_pkg::op_e                   op_i,
  input  tps_pkg::entry_t                entry_i,
  input  logic [tps_pkg::FRAME_W-1:0]    frame_i,
  input  logic [tps_pkg::ID_W-1:0]       id_i,
  output tps_pkg::eval_t                 eval_o
);
  import tps_pkg::*;

  logic [FRAME_W-1:0] age;
  logic [AGE_W-1:0]   age_plus;
  logic [SCORE_W-1:0] product;
  logic [MISS_W-1:0]  excess;
  logic [BOOST_W-1:0] boosted;
  logic [PRIO_W-1:0]  new_adapt;
  logic [MISS_W-1:0]  new_miss;

  // Age-weighted fixed priority: frames since the last request, plus one.
  always_comb begin
    age      = frame_i - entry_i.last_frame;
    age_plus = AGE_W'(age) + AGE_W'(1);
    product  = SCORE_W'(entry_i.fixed_prio) * SCORE_W'(age_plus);
  end

  // Adaptive priority: boost by missed responses, else decay toward fixed.
  always_comb begin
    excess  = entry_i.miss_count - MISS_THRESHOLD;
    boosted = BOOST_W'(entry_i.fixed_prio) + BOOST_W'({excess, 1'b0});
    if (entry_i.miss_count > MISS_THRESHOLD) begin
      if (boosted > BOOST_W'(PRIO_CAP)) begin
        new_adapt = PRIO_CAP;
      end else begin
        new_adapt = boosted[PRIO_W-1:0];
      end
    end else if (entry_i.adapt_prio > entry_i.fixed_prio) begin
      new_adapt = entry_i.adapt_prio - PRIO_W'(1);
    end else begin
      new_adapt = entry_i.adapt_prio;
    end
  end

  // Request bookkeeping: saturating miss counter.
  always_comb begin
    if (entry_i.miss_count == MISS_MAX) begin
      new_miss = MISS_MAX;
    end else begin
      new_miss = entry_i.miss_count + MISS_W'(1);
    end
  end

  // Select the outputs for the operation in progress.
  always_comb begin
    eval_o.match = (entry_i.ident == id_i);
    eval_o.upd   = entry_i;
    eval_o.score = '0;
    case (op_i)
      OP_REQUEST: begin
        eval_o.upd.last_frame = frame_i;
        eval_o.upd.miss_count = new_miss;
      end
      OP_FIXED: begin
        eval_o.score = product;
      end
      OP_ADAPT: begin
        eval_o.score          = SCORE_W'(new_adapt);
        eval_o.upd.adapt_prio = new_adapt;
      end
      default: begin
        eval_o.score = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/telemetry_poll_scheduler_unit.sv
// Channel  | Direction | Signals                         | Content
// s_axis   | in        | tvalid, tready, tdata, tuser    | one event request
// m_axis   | out       | tvalid, tready, tdata           | selected device id
// cfg      | in        | valid, ready, data              | strategy register
//
// Clear and frame tick events complete in the idle state. A round robin select
// passes through the S_RR and S_RESULT states to the output register. A request
// event or a priority select walks the bus table through the single read port of
// the entry RAM, one entry a cycle. A select waits while the output register is
// full; no request is taken until the sequencer is idle. Reset clears the counters
// and strategy, not the RAM.
module telemetry_poll_scheduler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: device_id [7:0], frame_number [23:8]
  input  logic [tps_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: mode [1:0], bus [2]
  input  logic [tps_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: selected_id [7:0]
  output logic [tps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tps_pkg::STRAT_W-1:0]    cfg_data_i
);
  import tps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_RR     = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [BUS_W-1:0] b,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(32'(b) * DEVICES + 32'(idx));
  endfunction

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  strategy_e            strategy_q;
  logic [BUS_W-1:0]     bus_q, bus_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [SCORE_W-1:0]   best_score_q, best_score_d;
  logic [ID_W-1:0]      best_id_q, best_id_d;
  logic [ID_W-1:0]      res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic [ID_W-1:0]      out_data_q, out_data_d;
  logic [CNT_W-1:0]     dev_total_q [BUSES];
  logic [CNT_W-1:0]     dev_total_d [BUSES];
  logic [IDX_W-1:0]     rr_ptr_q [BUSES];
  logic [IDX_W-1:0]     rr_ptr_d [BUSES];
  logic [FRAME_W-1:0]   bus_frame_q [BUSES];
  logic [FRAME_W-1:0]   bus_frame_d [BUSES];

  logic                 in_fire;
  mode_e                in_mode;
  logic [BUS_W-1:0]     in_bus;
  logic [ID_W-1:0]      in_id;
  logic [FRAME_W-1:0]   in_frame;
  logic                 in_bus_ok;
  logic [CNT_W-1:0]     in_total;
  logic [IDX_W-1:0]     rr_next;
  logic [CNT_W-1:0]     cur_total;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  entry_t               ram_rdata;
  logic [ENTRY_W-1:0]   ram_rdata_raw;
  eval_t                eval;
  entry_t               new_entry;

  // Stream unpacking.
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_mode  = mode_e'(s_axis_tuser[MODE_W-1:0]);
  assign in_bus   = s_axis_tuser[MODE_W +: BUS_W];
  assign in_id    = s_axis_tdata[ID_W-1:0];
  assign in_frame = s_axis_tdata[ID_W +: FRAME_W];
  assign in_bus_ok = (32'(in_bus) < BUSES);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // Entry table storage for all buses.
  tps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Shared evaluation unit, fed by the entry coming out of the RAM.
  tps_eval u_eval (
    .op_i    (op_q),
    .entry_i (ram_rdata),
    .frame_i (bus_frame_q[bus_q]),
    .id_i    (id_q),
    .eval_o  (eval)
  );

  // Entry appended for a device not yet in the table.
  always_comb begin
    new_entry.ident      = id_q;
    new_entry.fixed_prio = prio_of(id_q);
    new_entry.last_frame = bus_frame_q[bus_q];
    new_entry.miss_count = MISS_W'(1);
    new_entry.adapt_prio = PRIO_START;
  end

  assign in_total  = in_bus_ok ? dev_total_q[in_bus] : '0;
  assign cur_total = dev_total_q[bus_q];
  assign rr_next   = ((CNT_W'(rr_ptr_q[in_bus]) + CNT_W'(1)) == in_total) ? '0
                   : rr_ptr_q[in_bus] + IDX_W'(1);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    bus_d        = bus_q;
    id_d         = id_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    best_score_d = best_score_q;
    best_id_d    = best_id_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    dev_total_d  = dev_total_q;
    rr_ptr_d     = rr_ptr_q;
    bus_frame_d  = bus_frame_q;
    ram_we       = 1'b0;
    ram_waddr    = entry_addr(bus_q, rd_idx_q);
    ram_wdata    = eval.upd;
    ram_raddr    = entry_addr(bus_q, issue_q[IDX_W-1:0]);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          bus_d        = in_bus;
          id_d         = in_id;
          issue_d      = '0;
          best_score_d = '0;
          best_id_d    = NO_DEVICE;
          unique case (in_mode)
            MODE_CLEAR: begin
              if (in_bus_ok) begin
                dev_total_d[in_bus] = '0;
                rr_ptr_d[in_bus]    = '0;
                bus_frame_d[in_bus] = '0;
              end
            end
            MODE_TICK: begin
              if (in_bus_ok) begin
                bus_frame_d[in_bus] = in_frame;
              end
            end
            MODE_REQUEST: begin
              if (in_bus_ok && in_id != ID_NONE && in_id != NO_DEVICE) begin
                op_d    = OP_REQUEST;
                state_d = S_SCAN;
              end
            end
            MODE_SELECT: begin
              if (!in_bus_ok || in_total == '0) begin
                res_d   = NO_DEVICE;
                state_d = S_RESULT;
              end else begin
                unique case (strategy_q)
                  STRAT_RR: begin
                    rr_ptr_d[in_bus] = rr_next;
                    ram_raddr        = entry_addr(in_bus, rr_next);
                    state_d          = S_RR;
                  end
                  STRAT_FIXED: begin
                    op_d    = OP_FIXED;
                    state_d = S_SCAN;
                  end
                  STRAT_ADAPT: begin
                    op_d    = OP_ADAPT;
                    state_d = S_SCAN;
                  end
                  default: begin
                    res_d   = NO_DEVICE;
                    state_d = S_RESULT;
                  end
                endcase
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RR: begin
        res_d   = ram_rdata.ident;
        state_d = S_RESULT;
      end

      S_SCAN: begin
        // Issue the next table read.
        if (issue_q < cur_total) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IDX_W-1:0];
          issue_d  = issue_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          // Evaluate the entry that the RAM returns this cycle.
          case (op_q)
            OP_REQUEST: begin
              if (eval.match) begin
                ram_we   = 1'b1;
                rd_vld_d = 1'b0;
                state_d  = S_IDLE;
              end
            end
            OP_FIXED: begin
              if (eval.score > best_score_q) begin
                best_score_d = eval.score;
                best_id_d    = ram_rdata.ident;
              end
            end
            OP_ADAPT: begin
              ram_we = 1'b1;
              if (eval.score > best_score_q) begin
                best_score_d = eval.score;
                best_id_d    = ram_rdata.ident;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else if (issue_q >= cur_total) begin
          // Table walked to its end.
          if (op_q == OP_REQUEST) begin
            if (cur_total < CNT_W'(DEVICES)) begin
              ram_we             = 1'b1;
              ram_waddr          = entry_addr(bus_q, cur_total[IDX_W-1:0]);
              ram_wdata          = new_entry;
              dev_total_d[bus_q] = cur_total + CNT_W'(1);
            end
            state_d = S_IDLE;
          end else begin
            res_d   = best_id_q;
            state_d = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strategy_q  <= STRAT_RR;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dev_total_q <= '{default: '0};
      rr_ptr_q    <= '{default: '0};
      bus_frame_q <= '{default: '0};
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      dev_total_q <= dev_total_d;
      rr_ptr_q    <= rr_ptr_d;
      bus_frame_q <= bus_frame_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strategy_q <= strategy_e'(cfg_data_i);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    bus_q        <= bus_d;
    id_q         <= id_d;
    issue_q      <= issue_d;
    rd_idx_q     <= rd_idx_d;
    best_score_q <= best_score_d;
    best_id_q    <= best_id_d;
    res_q        <= res_d;
    out_data_q   <= out_data_d;
  end

`ifndef SYNTHESIS
  // The entry RAM is written only while the table is being walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_SCAN)
    else $error("entry RAM written outside a table walk");

  // Every entry evaluated lies inside the bus table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rd_vld_q) |-> CNT_W'(rd_idx_q) < dev_total_q[bus_q])
    else $error("entry read beyond the table fill");

  // The table never holds more devices than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> dev_total_q[bus_q] <= CNT_W'(DEVICES))
    else $error("device count beyond table size");

  // A finished select reaches the output register when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("result not loaded into a free output register");
`endif

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Idle wait after the last selection; leave a wide margin for a table walk to finish.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned SATURATE_ITEMS = 420;
  localparam int unsigned HOLD_START = 3000;
  localparam int unsigned HOLD_LEN = 800;
  localparam logic [ID_W-1:0] HOT_ID = 8'hB3;

  // One event request as offered on the input stream.
  typedef struct packed {
    mode_e              mode;
    logic [BUS_W-1:0]   bus;
    logic [ID_W-1:0]    id;
    logic [FRAME_W-1:0] frame;
    logic               typed;
    logic [ID_W-1:0]    want;
  } poll_event_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_e;

  // Directed requests. Rows marked typed carry their expected selection.
  localparam poll_event_t PLAN [23] = '{
    '{MODE_SELECT,  1'b0, 8'h00, 16'h0000, 1'b1, NO_DEVICE},
    '{MODE_SELECT,  1'b1, 8'h00, 16'h0000, 1'b1, NO_DEVICE},
    '{MODE_REQUEST, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b0, 8'h00, 16'h0000, 1'b1, NO_DEVICE},
    '{MODE_TICK,    1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'h01, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'h35, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'h4A, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'hB7, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'hFE, 16'h0000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b0, 8'h01, 16'hFFFF, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b0, 8'h00, 16'h0000, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'h00},
    '{MODE_TICK,    1'b0, 8'h00, 16'h0002, 1'b0, 8'h00},
    '{MODE_TICK,    1'b1, 8'h00, 16'h8000, 1'b0, 8'h00},
    '{MODE_REQUEST, 1'b1, 8'h2C, 16'h0000, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b1, 8'h00, 16'h0000, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b0, 8'h00, 16'h0000, 1'b0, 8'h00},
    '{MODE_CLEAR,   1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b1, 8'h00, 16'h0000, 1'b1, NO_DEVICE},
    '{MODE_REQUEST, 1'b1, 8'h80, 16'h0000, 1'b0, 8'h00},
    '{MODE_SELECT,  1'b1, 8'h00, 16'h0000, 1'b0, 8'h00}
  };

  // More ids than a table holds, spread over every priority class.
  localparam logic [ID_W-1:0] ID_POOL [20] = '{
    8'h01, 8'h12, 8'h23, 8'h2F, 8'h30, 8'h3C, 8'h41, 8'h4E, 8'hB0, 8'hBF,
    8'h55, 8'h67, 8'h78, 8'h89, 8'h9A, 8'hAB, 8'hCD, 8'hDE, 8'hEF, 8'hF1
  };

  localparam strategy_e PHASES [9] = '{
    STRAT_FIXED, STRAT_ADAPT, STRAT_NONE, STRAT_RR, STRAT_ADAPT,
    STRAT_FIXED, STRAT_RR, STRAT_ADAPT, STRAT_FIXED
  };

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [STRAT_W-1:0]     cfg_data_i = '0;

  // Shadow copy of the scheduler state.
  logic [ID_W-1:0]    dev_id    [BUSES][DEVICES];
  logic [PRIO_W-1:0]  dev_fixed [BUSES][DEVICES];
  logic [FRAME_W-1:0] dev_last  [BUSES][DEVICES];
  logic [MISS_W-1:0]  dev_miss  [BUSES][DEVICES];
  logic [PRIO_W-1:0]  dev_adapt [BUSES][DEVICES];
  logic [CNT_W-1:0]   dev_count [BUSES] = '{default: '0};
  logic [IDX_W-1:0]   rr_ptr    [BUSES] = '{default: '0};
  logic [FRAME_W-1:0] bus_frame [BUSES] = '{default: '0};
  strategy_e          poll_strategy = STRAT_RR;

  logic [ID_W-1:0] pending_picks [$];
  logic [ID_W-1:0] pick_want;
  int unsigned     fail_count = 0;
  int unsigned     burst_left = 0;
  int unsigned     rx_cycles = 0;
  int unsigned     hold_left = 0;
  int unsigned     style_left = 0;
  stall_e          stall_style = STALL_NONE;

  telemetry_poll_scheduler_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one request to the shadow state; returns 1 when it yields a selection.
  function automatic bit apply_event(input poll_event_t ev, output logic [ID_W-1:0] pick);
    int                 n;
    int                 slot;
    int                 top;
    int                 top_score;
    int                 score;
    int                 boosted;
    logic [FRAME_W-1:0] age;
    logic [BUS_W-1:0]   b;
    b = ev.bus;
    n = int'(dev_count[b]);
    pick = NO_DEVICE;
    case (ev.mode)
      MODE_CLEAR: begin
        dev_count[b] = '0;
        rr_ptr[b] = '0;
        bus_frame[b] = '0;
        return 1'b0;
      end
      MODE_TICK: begin
        bus_frame[b] = ev.frame;
        return 1'b0;
      end
      MODE_REQUEST: begin
        if (ev.id == ID_NONE || ev.id == NO_DEVICE) return 1'b0;
        slot = n;
        for (int i = 0; i < n; i++) begin
          if (dev_id[b][i] == ev.id && slot == n) slot = i;
        end
        if (slot == n) begin
          // A new device is appended only while the table has room.
          if (n >= DEVICES) return 1'b0;
          dev_id[b][n] = ev.id;
          case (ev.id[7:4])
            4'h0, 4'h1, 4'h2: dev_fixed[b][n] = PRIO_HIGH;
            4'h3:             dev_fixed[b][n] = PRIO_MID;
            4'h4:             dev_fixed[b][n] = PRIO_LOW;
            4'hB:             dev_fixed[b][n] = PRIO_LOWEST;
            default:          dev_fixed[b][n] = PRIO_MID;
          endcase
          dev_miss[b][n] = '0;
          dev_adapt[b][n] = PRIO_START;
          dev_count[b] = CNT_W'(n + 1);
        end
        dev_last[b][slot] = bus_frame[b];
        if (dev_miss[b][slot] != MISS_MAX) dev_miss[b][slot] = dev_miss[b][slot] + 1'b1;
        return 1'b0;
      end
      default: begin
      end
    endcase

    // Selection.
    if (poll_strategy == STRAT_NONE || n == 0) return 1'b1;
    top = 0;
    top_score = 0;
    case (poll_strategy)
      STRAT_RR: begin
        rr_ptr[b] = IDX_W'((int'(rr_ptr[b]) + 1) % n);
        top = int'(rr_ptr[b]);
      end
      STRAT_FIXED: begin
        // Priority weighted by frames since the last request, wrapping at 16 bits.
        for (int i = 0; i < n; i++) begin
          age = bus_frame[b] - dev_last[b][i];
          score = int'(dev_fixed[b][i]) * (int'(age) + 1);
          if (score > top_score) begin
            top_score = score;
            top = i;
          end
        end
      end
      default: begin
        // Boost by missed responses, capped; otherwise decay toward the fixed priority.
        for (int i = 0; i < n; i++) begin
          if (dev_miss[b][i] > MISS_THRESHOLD) begin
            boosted = int'(dev_fixed[b][i]) +
                      (int'(dev_miss[b][i]) - int'(MISS_THRESHOLD)) * 2;
            if (boosted > int'(PRIO_CAP)) boosted = int'(PRIO_CAP);
            dev_adapt[b][i] = PRIO_W'(boosted);
          end else if (dev_adapt[b][i] > dev_fixed[b][i]) begin
            dev_adapt[b][i] = dev_adapt[b][i] - 1'b1;
          end
        end
        for (int i = 0; i < n; i++) begin
          if (int'(dev_adapt[b][i]) > top_score) begin
            top_score = int'(dev_adapt[b][i]);
            top = i;
          end
        end
      end
    endcase
    pick = dev_id[b][top];
    return 1'b1;
  endfunction

  // Random request: mostly requests to pooled ids, with ticks, selects and rare clears.
  function automatic poll_event_t random_event();
    poll_event_t ev;
    int          r;
    int          k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 19);
    ev.bus = BUS_W'($urandom_range(0, 1));
    ev.id = ID_W'($urandom_range(0, 255));
    ev.frame = FRAME_W'($urandom_range(0, 65535));
    ev.typed = 1'b0;
    ev.want = '0;
    if (r < 2) begin
      ev.mode = MODE_CLEAR;
    end else if (r < 17) begin
      ev.mode = MODE_TICK;
      if (k < 12) ev.frame = bus_frame[ev.bus] + FRAME_W'($urandom_range(1, 5));
      else if (k < 16) ev.frame = bus_frame[ev.bus] + FRAME_W'($urandom_range(100, 3000));
    end else if (r < 70) begin
      ev.mode = MODE_REQUEST;
      if (k < 16) ev.id = ID_POOL[$urandom_range(0, 19)];
      else if (k == 18) ev.id = ID_NONE;
      else if (k == 19) ev.id = NO_DEVICE;
    end else begin
      ev.mode = MODE_SELECT;
    end
    return ev;
  endfunction

  // Offers one request in bursts with random gaps, then records the expected selection.
  task automatic offer_event(input poll_event_t ev);
    logic [ID_W-1:0] pick;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ev.frame, ev.id};
    s_axis_tuser <= {ev.bus, ev.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    if (apply_event(ev, pick)) pending_picks.push_back(ev.typed ? ev.want : pick);
  endtask

  // Waits for the block to go idle, then writes the strategy register.
  task automatic set_strategy(input strategy_e s);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    poll_strategy = s;
  endtask

  // Output side: stall patterns that change every so often, plus one long hold-off.
  always @(posedge clk_i) begin
    rx_cycles++;
    if (rx_cycles == HOLD_START) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 160);
      end
      style_left--;
      case (stall_style)
        STALL_NONE:    m_axis_tready <= 1'b1;
        STALL_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        STALL_PATTERN: m_axis_tready <= (rx_cycles % 4) != 0;
        default:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each selection against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_picks.size() == 0) begin
        $error("selected_id: no selection expected, got %0d", m_axis_tdata);
        fail_count++;
      end else begin
        pick_want = pending_picks.pop_front();
        if (m_axis_tdata !== pick_want) begin
          $error("selected_id mismatch: expected %0d, got %0d", pick_want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus.
  initial begin
    poll_event_t ev;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) offer_event(PLAN[i]);

    foreach (PHASES[p]) begin
      set_strategy(PHASES[p]);
      repeat (PHASE_ITEMS) offer_event(random_event());
    end

    // Hammer one low-priority device so its miss counter saturates and its
    // adaptive priority climbs to the cap.
    set_strategy(STRAT_ADAPT);
    ev = '{MODE_CLEAR, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00};
    offer_event(ev);
    for (int i = 0; i < SATURATE_ITEMS; i++) begin
      if (i % 8 == 5) begin
        offer_event(random_event());
      end else begin
        ev.mode = (i % 4 == 3) ? MODE_SELECT : MODE_REQUEST;
        ev.bus = 1'b0;
        ev.id = HOT_ID;
        ev.frame = FRAME_W'($urandom_range(0, 65535));
        offer_event(ev);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
